// ----- hw/rtl/mtep_pkg.sv -----
package mtep_pkg;

    localparam int ACC_W = 28;

    localparam logic [2:0] ROLE_DELTA    = 3'd0;
    localparam logic [2:0] ROLE_STATUS   = 3'd1;
    localparam logic [2:0] ROLE_IMPLICIT = 3'd2;
    localparam logic [2:0] ROLE_MTYPE    = 3'd3;
    localparam logic [2:0] ROLE_LENGTH   = 3'd4;
    localparam logic [2:0] ROLE_DATA     = 3'd5;
    localparam logic [2:0] ROLE_IGNORED  = 3'd6;

    localparam logic [1:0] CLASS_CHANNEL = 2'd0;
    localparam logic [1:0] CLASS_META    = 2'd1;
    localparam logic [1:0] CLASS_SYSEX   = 2'd2;
    localparam logic [1:0] CLASS_NONE    = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_STRAY   = 2'd1;
    localparam logic [1:0] ERR_META    = 2'd2;
    localparam logic [1:0] ERR_OVERLONG = 2'd3;

    localparam logic [7:0] STATUS_SYS    = 8'hF0;
    localparam logic [7:0] STATUS_MIN    = 8'h80;
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] SYSEX_END     = 8'hF7;
    localparam logic [3:0] GROUP_PROGRAM = 4'hC;
    localparam logic [3:0] GROUP_PRESS   = 4'hD;

    localparam logic [7:0] META_TEXT_MAX = 8'h09;
    localparam logic [7:0] META_CHAN_PFX = 8'h20;
    localparam logic [7:0] META_PORT     = 8'h21;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_SMPTE    = 8'h54;
    localparam logic [7:0] META_TIMESIG  = 8'h58;
    localparam logic [7:0] META_KEYSIG   = 8'h59;
    localparam logic [7:0] META_SEQSPEC  = 8'h7F;

    function automatic logic known_meta(input logic [7:0] t);
        return (t <= META_TEXT_MAX) || (t == META_CHAN_PFX) || (t == META_PORT) ||
               (t == META_EOT) || (t == META_TEMPO) || (t == META_SMPTE) ||
               (t == META_TIMESIG) || (t == META_KEYSIG) || (t == META_SEQSPEC);
    endfunction

    function automatic logic [ACC_W-1:0] channel_len(input logic [7:0] s);
        if ((s[7:4] == GROUP_PROGRAM) || (s[7:4] == GROUP_PRESS)) begin
            return ACC_W'(1);
        end
        return ACC_W'(2);
    endfunction

endpackage

// ----- hw/rtl/midi_track_event_parser_top.sv -----
// MIDI track event parser.
// Input channel (s_valid/s_ready): one raw track event byte per item, with
// s_track_start high on the first byte of a track; that byte restarts all
// event state, running status and the held error before it is decoded.
// Result channel (m_valid/m_ready): one item per input byte giving the
// byte's role, event class, status in force, meta type, delta time, payload
// length and index, end-of-event flag, held error and a sysex warning.
// m_valid rises in the cycle after acceptance. While m_ready is high, one
// item is taken every cycle: the per-byte state update is a single pass of
// decode logic ahead of the result register, for one byte per cycle.
// The input is taken whenever the result register is empty or is being
// drained in the same cycle; a stalled receiver holds the result and
// back-pressures the input after one item.
// Reset (aresetn low, synchronous) empties the result register and returns
// the parser to waiting for a delta time with no running status.
// MAX_VLQ_BYTES bounds the bytes of a delta or length field.
module midi_track_event_parser_top
    import mtep_pkg::*;
#(
    parameter int MAX_VLQ_BYTES = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_track_byte,
    input  logic             s_track_start,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_byte_role,
    output logic [1:0]       m_event_class,
    output logic [7:0]       m_effective_status,
    output logic [7:0]       m_meta_kind,
    output logic [ACC_W-1:0] m_delta_ticks,
    output logic [ACC_W-1:0] m_payload_length,
    output logic [ACC_W-1:0] m_payload_index,
    output logic             m_event_done,
    output logic [1:0]       m_error_code,
    output logic             m_casio_warning
);

    localparam int VLQ_W = $clog2(MAX_VLQ_BYTES + 1);
    localparam logic [VLQ_W-1:0] VLQ_MAX = VLQ_W'(MAX_VLQ_BYTES);

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_MTYPE,
        PH_LENGTH,
        PH_DATA,
        PH_ERROR
    } phase_t;

    phase_t             phase_reg, phase_next, cur_phase;
    logic               running_reg, running_next;
    logic [7:0]         saved_reg, saved_next;
    logic [1:0]         class_reg, class_next;
    logic [7:0]         meta_reg, meta_next;
    logic [ACC_W-1:0]   delta_reg, delta_next;
    logic [ACC_W-1:0]   len_reg, len_next;
    logic [VLQ_W-1:0]   vlq_reg, vlq_next;
    logic [ACC_W-1:0]   dcnt_reg, dcnt_next;
    logic [1:0]         err_reg, err_next;

    logic               m_valid_reg;
    logic [2:0]         role_reg, role_next;
    logic [1:0]         oclass_reg, oclass_next;
    logic [7:0]         ostatus_reg, ostatus_next;
    logic [7:0]         ometa_reg, ometa_next;
    logic [ACC_W-1:0]   odelta_reg, odelta_next;
    logic [ACC_W-1:0]   olen_reg, olen_next;
    logic [ACC_W-1:0]   pidx_reg, pidx_next;
    logic               done_reg, done_next;
    logic [1:0]         oerr_reg, oerr_next;
    logic               warn_reg, warn_next;

    logic [2:0]         role;
    logic               done;
    logic               warn;
    logic [ACC_W-1:0]   pidx;
    logic               s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        cur_phase    = s_track_start ? PH_DELTA : phase_reg;
        phase_next   = cur_phase;
        running_next = s_track_start ? 1'b0 : running_reg;
        saved_next   = s_track_start ? STATUS_META : saved_reg;
        class_next   = s_track_start ? CLASS_NONE : class_reg;
        meta_next    = s_track_start ? 8'h00 : meta_reg;
        delta_next   = s_track_start ? '0 : delta_reg;
        len_next     = s_track_start ? '0 : len_reg;
        vlq_next     = s_track_start ? '0 : vlq_reg;
        dcnt_next    = s_track_start ? '0 : dcnt_reg;
        err_next     = s_track_start ? ERR_NONE : err_reg;
        role         = ROLE_IGNORED;
        done         = 1'b0;
        warn         = 1'b0;
        pidx         = '0;

        case (cur_phase)
            PH_DELTA: begin
                if (vlq_next == '0) begin
                    delta_next = '0;
                    len_next   = '0;
                    dcnt_next  = '0;
                    class_next = CLASS_NONE;
                    meta_next  = 8'h00;
                end
                role = ROLE_DELTA;
                if (vlq_next >= VLQ_MAX) begin
                    err_next   = ERR_OVERLONG;
                    phase_next = PH_ERROR;
                end else begin
                    delta_next = {delta_next[ACC_W-8:0], s_track_byte[6:0]};
                    vlq_next   = vlq_next + VLQ_W'(1);
                    if (!s_track_byte[7]) begin
                        vlq_next   = '0;
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_STATUS: begin
                if ((s_track_byte >= STATUS_MIN) && (s_track_byte < STATUS_SYS)) begin
                    saved_next   = s_track_byte;
                    running_next = 1'b1;
                    class_next   = CLASS_CHANNEL;
                    len_next     = channel_len(s_track_byte);
                    dcnt_next    = '0;
                    phase_next   = PH_DATA;
                    role         = ROLE_STATUS;
                end else if (!s_track_byte[7] && running_next) begin
                    class_next = CLASS_CHANNEL;
                    len_next   = channel_len(saved_next);
                    role       = ROLE_IMPLICIT;
                    dcnt_next  = ACC_W'(1);
                    if (len_next == ACC_W'(1)) begin
                        done       = 1'b1;
                        phase_next = PH_DELTA;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else if (s_track_byte == STATUS_META) begin
                    saved_next   = s_track_byte;
                    running_next = 1'b0;
                    class_next   = CLASS_META;
                    phase_next   = PH_MTYPE;
                    role         = ROLE_STATUS;
                end else if (s_track_byte >= STATUS_SYS) begin
                    saved_next   = s_track_byte;
                    running_next = 1'b0;
                    class_next   = CLASS_SYSEX;
                    vlq_next     = '0;
                    phase_next   = PH_LENGTH;
                    role         = ROLE_STATUS;
                end else begin
                    err_next   = ERR_STRAY;
                    phase_next = PH_ERROR;
                end
            end
            PH_MTYPE: begin
                meta_next = s_track_byte;
                role      = ROLE_MTYPE;
                if (known_meta(s_track_byte)) begin
                    vlq_next   = '0;
                    phase_next = PH_LENGTH;
                end else begin
                    err_next   = ERR_META;
                    phase_next = PH_ERROR;
                end
            end
            PH_LENGTH: begin
                role = ROLE_LENGTH;
                if (vlq_next >= VLQ_MAX) begin
                    err_next   = ERR_OVERLONG;
                    phase_next = PH_ERROR;
                end else begin
                    len_next = {len_next[ACC_W-8:0], s_track_byte[6:0]};
                    vlq_next = vlq_next + VLQ_W'(1);
                    if (!s_track_byte[7]) begin
                        vlq_next  = '0;
                        dcnt_next = '0;
                        if (len_next == '0) begin
                            done       = 1'b1;
                            phase_next = PH_DELTA;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                role      = ROLE_DATA;
                pidx      = dcnt_next;
                dcnt_next = dcnt_next + ACC_W'(1);
                if (dcnt_next >= len_next) begin
                    done       = 1'b1;
                    phase_next = PH_DELTA;
                    if ((class_next == CLASS_SYSEX) && (s_track_byte != SYSEX_END)) begin
                        warn = 1'b1;
                    end
                end
            end
            default: begin
                role = ROLE_IGNORED;
            end
        endcase

        if (role == ROLE_IGNORED) begin
            role_next    = ROLE_IGNORED;
            oclass_next  = CLASS_NONE;
            ostatus_next = STATUS_META;
            ometa_next   = 8'h00;
            odelta_next  = '0;
            olen_next    = '0;
            pidx_next    = '0;
            done_next    = 1'b0;
            warn_next    = 1'b0;
        end else begin
            role_next   = role;
            oclass_next = class_next;
            if (class_next == CLASS_NONE) begin
                ostatus_next = running_next ? saved_next : STATUS_META;
            end else begin
                ostatus_next = saved_next;
            end
            ometa_next  = (class_next == CLASS_META) ? meta_next : 8'h00;
            odelta_next = delta_next;
            olen_next   = (class_next == CLASS_NONE) ? '0 : len_next;
            pidx_next   = pidx;
            done_next   = done;
            warn_next   = warn;
        end
        oerr_next = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DELTA;
            running_reg <= 1'b0;
            saved_reg   <= STATUS_META;
            class_reg   <= CLASS_NONE;
            meta_reg    <= 8'h00;
            delta_reg   <= '0;
            len_reg     <= '0;
            vlq_reg     <= '0;
            dcnt_reg    <= '0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg   <= phase_next;
                running_reg <= running_next;
                saved_reg   <= saved_next;
                class_reg   <= class_next;
                meta_reg    <= meta_next;
                delta_reg   <= delta_next;
                len_reg     <= len_next;
                vlq_reg     <= vlq_next;
                dcnt_reg    <= dcnt_next;
                err_reg     <= err_next;
                role_reg    <= role_next;
                oclass_reg  <= oclass_next;
                ostatus_reg <= ostatus_next;
                ometa_reg   <= ometa_next;
                odelta_reg  <= odelta_next;
                olen_reg    <= olen_next;
                pidx_reg    <= pidx_next;
                done_reg    <= done_next;
                oerr_reg    <= oerr_next;
                warn_reg    <= warn_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_byte_role        = role_reg;
    assign m_event_class      = oclass_reg;
    assign m_effective_status = ostatus_reg;
    assign m_meta_kind        = ometa_reg;
    assign m_delta_ticks      = odelta_reg;
    assign m_payload_length   = olen_reg;
    assign m_payload_index    = pidx_reg;
    assign m_event_done       = done_reg;
    assign m_error_code       = oerr_reg;
    assign m_casio_warning    = warn_reg;

endmodule

// ----- tb/sv/tb_midi_track_event_parser_top.sv -----
module tb_midi_track_event_parser_top
    import mtep_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VLQ_LIMIT   = 4;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 1300;

    typedef enum logic [2:0] {
        PH_DELTA, PH_STATUS, PH_MTYPE, PH_LENGTH, PH_DATA, PH_ERROR
    } parse_phase_t;

    typedef struct {
        logic [2:0]       role;
        logic [1:0]       ev_class;
        logic [7:0]       status;
        logic [7:0]       meta;
        logic [ACC_W-1:0] delta;
        logic [ACC_W-1:0] length;
        logic [ACC_W-1:0] index;
        logic             done;
        logic [1:0]       err;
        logic             warn;
    } byte_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_track_byte = 8'h00;
    logic             s_track_start = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [2:0]       m_byte_role;
    logic [1:0]       m_event_class;
    logic [7:0]       m_effective_status;
    logic [7:0]       m_meta_kind;
    logic [ACC_W-1:0] m_delta_ticks;
    logic [ACC_W-1:0] m_payload_length;
    logic [ACC_W-1:0] m_payload_index;
    logic             m_event_done;
    logic [1:0]       m_error_code;
    logic             m_casio_warning;

    parse_phase_t     ph;
    logic             run_on;
    logic [7:0]       last_status;
    logic [1:0]       cur_class;
    logic [7:0]       cur_meta;
    logic [ACC_W-1:0] delta_acc;
    logic [ACC_W-1:0] len_acc;
    logic [2:0]       vlq_n;
    logic [ACC_W-1:0] data_n;
    logic [1:0]       err_held;

    byte_result_t pending_results[$];
    logic         next_start = 1'b0;
    logic         no_idle = 1'b0;
    logic         long_hold_req = 1'b0;
    int           bytes_sent = 0;
    int           fail_count = 0;
    int           results_seen = 0;
    int           events_seen = 0;
    int           warnings_seen = 0;
    int           errored_seen = 0;

    midi_track_event_parser_top #(
        .MAX_VLQ_BYTES(VLQ_LIMIT)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_track_byte      (s_track_byte),
        .s_track_start     (s_track_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_byte_role       (m_byte_role),
        .m_event_class     (m_event_class),
        .m_effective_status(m_effective_status),
        .m_meta_kind       (m_meta_kind),
        .m_delta_ticks     (m_delta_ticks),
        .m_payload_length  (m_payload_length),
        .m_payload_index   (m_payload_index),
        .m_event_done      (m_event_done),
        .m_error_code      (m_error_code),
        .m_casio_warning   (m_casio_warning)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic is_listed_meta(input logic [7:0] t);
        return (t <= META_TEXT_MAX) || (t == META_CHAN_PFX) || (t == META_PORT) ||
               (t == META_EOT) || (t == META_TEMPO) || (t == META_SMPTE) ||
               (t == META_TIMESIG) || (t == META_KEYSIG) || (t == META_SEQSPEC);
    endfunction

    function automatic int chan_data_len(input logic [7:0] s);
        return ((s[7:4] == GROUP_PROGRAM) || (s[7:4] == GROUP_PRESS)) ? 1 : 2;
    endfunction

    function automatic void clear_parser();
        ph          = PH_DELTA;
        run_on      = 1'b0;
        last_status = STATUS_META;
        cur_class   = CLASS_NONE;
        cur_meta    = 8'h00;
        delta_acc   = '0;
        len_acc     = '0;
        vlq_n       = '0;
        data_n      = '0;
        err_held    = ERR_NONE;
    endfunction

    function automatic byte_result_t decode_byte(input logic [7:0] b, input logic st);
        byte_result_t r;
        logic [2:0]       role;
        logic             done;
        logic             warn;
        logic [ACC_W-1:0] pidx;
        role = ROLE_IGNORED;
        done = 1'b0;
        warn = 1'b0;
        pidx = '0;
        if (st) clear_parser();
        case (ph)
            PH_DELTA: begin
                if (vlq_n == 0) begin
                    delta_acc = '0;
                    len_acc   = '0;
                    data_n    = '0;
                    cur_class = CLASS_NONE;
                    cur_meta  = 8'h00;
                end
                role = ROLE_DELTA;
                if (vlq_n >= VLQ_LIMIT) begin
                    err_held = ERR_OVERLONG;
                    ph = PH_ERROR;
                end else begin
                    delta_acc = {delta_acc[ACC_W-8:0], b[6:0]};
                    vlq_n++;
                    if (!b[7]) begin
                        vlq_n = '0;
                        ph = PH_STATUS;
                    end
                end
            end
            PH_STATUS: begin
                if (b >= STATUS_MIN && b < STATUS_SYS) begin
                    last_status = b;
                    run_on      = 1'b1;
                    cur_class   = CLASS_CHANNEL;
                    len_acc     = ACC_W'(chan_data_len(b));
                    data_n      = '0;
                    ph          = PH_DATA;
                    role        = ROLE_STATUS;
                end else if (b < STATUS_MIN && run_on) begin
                    cur_class = CLASS_CHANNEL;
                    len_acc   = ACC_W'(chan_data_len(last_status));
                    role      = ROLE_IMPLICIT;
                    data_n    = ACC_W'(1);
                    if (len_acc == ACC_W'(1)) begin
                        done = 1'b1;
                        ph = PH_DELTA;
                    end else begin
                        ph = PH_DATA;
                    end
                end else if (b == STATUS_META) begin
                    last_status = b;
                    run_on      = 1'b0;
                    cur_class   = CLASS_META;
                    ph          = PH_MTYPE;
                    role        = ROLE_STATUS;
                end else if (b >= STATUS_SYS) begin
                    last_status = b;
                    run_on      = 1'b0;
                    cur_class   = CLASS_SYSEX;
                    vlq_n       = '0;
                    ph          = PH_LENGTH;
                    role        = ROLE_STATUS;
                end else begin
                    err_held = ERR_STRAY;
                    ph = PH_ERROR;
                end
            end
            PH_MTYPE: begin
                cur_meta = b;
                role = ROLE_MTYPE;
                if (is_listed_meta(b)) begin
                    vlq_n = '0;
                    ph = PH_LENGTH;
                end else begin
                    err_held = ERR_META;
                    ph = PH_ERROR;
                end
            end
            PH_LENGTH: begin
                role = ROLE_LENGTH;
                if (vlq_n >= VLQ_LIMIT) begin
                    err_held = ERR_OVERLONG;
                    ph = PH_ERROR;
                end else begin
                    len_acc = {len_acc[ACC_W-8:0], b[6:0]};
                    vlq_n++;
                    if (!b[7]) begin
                        vlq_n  = '0;
                        data_n = '0;
                        if (len_acc == 0) begin
                            done = 1'b1;
                            ph = PH_DELTA;
                        end else begin
                            ph = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                role = ROLE_DATA;
                pidx = data_n;
                data_n = data_n + 1'b1;
                if (data_n >= len_acc) begin
                    done = 1'b1;
                    ph = PH_DELTA;
                    if (cur_class == CLASS_SYSEX && b != SYSEX_END) warn = 1'b1;
                end
            end
            default: role = ROLE_IGNORED;
        endcase

        if (role == ROLE_IGNORED) begin
            r = '{ROLE_IGNORED, CLASS_NONE, STATUS_META, 8'h00, '0, '0, '0, 1'b0, err_held, 1'b0};
        end else begin
            r.role     = role;
            r.ev_class = cur_class;
            if (cur_class == CLASS_NONE) r.status = run_on ? last_status : STATUS_META;
            else r.status = last_status;
            r.meta     = (cur_class == CLASS_META) ? cur_meta : 8'h00;
            r.delta    = delta_acc;
            r.length   = (cur_class == CLASS_NONE) ? '0 : len_acc;
            r.index    = pidx;
            r.done     = done;
            r.err      = err_held;
            r.warn     = warn;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        logic st;
        int   gap;
        st = next_start;
        next_start = 1'b0;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_track_byte  <= b;
        s_track_start <= st;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        pending_results.push_back(decode_byte(b, st));
        bytes_sent++;
    endtask

    // most significant group first, optional leading zero groups, never past the limit
    task automatic send_vlq(input logic [ACC_W-1:0] v, input int pad);
        int n;
        n = 1;
        while (n < VLQ_LIMIT && (v >> (7 * n)) != 0) n++;
        if (pad > VLQ_LIMIT - n) pad = VLQ_LIMIT - n;
        repeat (pad) send_byte(8'h80);
        for (int i = n - 1; i >= 0; i--) send_byte({i != 0, v[7*i +: 7]});
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        byte_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, role %0d", $time, m_byte_role);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("byte_role", want.role, m_byte_role);
                check_field("event_class", want.ev_class, m_event_class);
                check_field("effective_status", want.status, m_effective_status);
                check_field("meta_kind", want.meta, m_meta_kind);
                check_field("delta_ticks", want.delta, m_delta_ticks);
                check_field("payload_length", want.length, m_payload_length);
                check_field("payload_index", want.index, m_payload_index);
                check_field("event_done", want.done, m_event_done);
                check_field("error_code", want.err, m_error_code);
                check_field("casio_warning", want.warn, m_casio_warning);
            end
            results_seen++;
            if (m_event_done) events_seen++;
            if (m_casio_warning) warnings_seen++;
            if (m_error_code != ERR_NONE) errored_seen++;
        end
    end

    initial begin
        int hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && $urandom_range(0, 3) == 0) begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_channel_events();
        next_start = 1'b1;
        send_byte(8'h00); send_byte(8'h90); send_byte(8'h3C); send_byte(8'h7F);
        send_byte(8'h81); send_byte(8'h00); send_byte(8'h3C); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'hC5); send_byte(8'h07);
        send_byte(8'h00); send_byte(8'h09);
        send_byte(8'h00); send_byte(8'hDF); send_byte(8'h40);
        send_byte(8'h00); send_byte(8'hEF); send_byte(8'h00); send_byte(8'h7F);
        send_vlq('1, 0);
        send_byte(STATUS_MIN); send_byte(8'h01); send_byte(8'h02);
    endtask

    task automatic test_meta_sysex();
        next_start = 1'b1;
        send_byte(8'h00); send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h03);
        send_byte(8'h07); send_byte(8'hA1); send_byte(8'h20);
        send_byte(8'h00); send_byte(STATUS_SYS); send_byte(8'h02);
        send_byte(8'h7E); send_byte(SYSEX_END);
        // sysex without a closing F7
        send_byte(8'h00); send_byte(STATUS_SYS); send_byte(8'h02);
        send_byte(8'h7E); send_byte(8'h7E);
        send_byte(8'h00); send_byte(SYSEX_END); send_byte(8'h00);
        send_byte(8'h00); send_byte(STATUS_META); send_byte(META_EOT); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'hFE); send_vlq(28'd2, 3);
        send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h00); send_byte(STATUS_META); send_byte(META_SEQSPEC); send_byte(8'h00);
    endtask

    task automatic test_errors();
        next_start = 1'b1;
        send_byte(8'h00); send_byte(8'h40); send_byte(8'h00); send_byte(8'h90);
        // meta clears running status, so the next bare data byte is stray
        next_start = 1'b1;
        send_byte(8'h00); send_byte(8'h90); send_byte(8'h3C); send_byte(8'h40);
        send_byte(8'h00); send_byte(STATUS_META); send_byte(8'h01); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h3C);
        next_start = 1'b1;
        send_byte(8'h00); send_byte(STATUS_META); send_byte(8'h30); send_byte(8'h00);
        next_start = 1'b1;
        send_byte(8'h81); send_byte(8'h82); send_byte(8'h83); send_byte(8'h84);
        send_byte(8'h05); send_byte(8'h00);
        next_start = 1'b1;
        send_byte(8'h00); send_byte(STATUS_SYS);
        repeat (4) send_byte(8'h80);
        send_byte(8'h01);
        // restart in the middle of a huge payload
        next_start = 1'b1;
        send_byte(8'h00); send_byte(STATUS_META); send_byte(8'h01); send_vlq('1, 0);
        send_byte(8'h41); send_byte(8'h42);
        next_start = 1'b1;
        send_byte(8'h85); send_byte(8'h00); send_byte(8'h90); send_byte(8'h10);
        send_byte(8'h20);
    endtask

    task automatic test_backpressure();
        s_valid <= 1'b0;
        @(negedge aclk);
        long_hold_req = 1'b1;
        @(posedge aclk);
        no_idle = 1'b1;
        next_start = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_vlq(ACC_W'($urandom_range(0, 5000)), 0);
            send_byte(8'($urandom_range(STATUS_MIN, STATUS_SYS - 1)));
            send_byte(8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_tracks(input int target);
        int         kind;
        int         n_ev;
        int         len;
        logic [7:0] st;
        logic [7:0] gen_status;
        logic       gen_running;
        gen_status = STATUS_MIN;
        while (bytes_sent < target) begin
            next_start = 1'b1;
            gen_running = 1'b0;
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) wait_drained();
            n_ev = $urandom_range(1, 12);
            for (int e = 0; e < n_ev; e++) begin
                if ($urandom_range(0, 7) == 0) send_vlq(ACC_W'($urandom), $urandom_range(0, 3));
                else send_vlq(ACC_W'($urandom_range(0, 200)), $urandom_range(0, 1));
                kind = $urandom_range(0, 99);
                if (kind >= 35 && kind < 55 && !gen_running) kind = 0;
                if (kind < 35) begin
                    st = 8'($urandom_range(STATUS_MIN, STATUS_SYS - 1));
                    send_byte(st);
                    repeat (chan_data_len(st)) send_byte(8'($urandom_range(0, 255)));
                    gen_status = st;
                    gen_running = 1'b1;
                end else if (kind < 55) begin
                    send_byte(8'($urandom_range(0, 127)));
                    if (chan_data_len(gen_status) == 2) send_byte(8'($urandom_range(0, 255)));
                end else if (kind < 70) begin
                    send_byte(STATUS_META);
                    if ($urandom_range(0, 1) == 0) begin
                        send_byte(8'($urandom_range(0, META_TEXT_MAX)));
                    end else begin
                        case ($urandom_range(0, 7))
                            0: send_byte(META_CHAN_PFX);
                            1: send_byte(META_PORT);
                            2: send_byte(META_EOT);
                            3: send_byte(META_TEMPO);
                            4: send_byte(META_SMPTE);
                            5: send_byte(META_TIMESIG);
                            6: send_byte(META_KEYSIG);
                            default: send_byte(META_SEQSPEC);
                        endcase
                    end
                    len = $urandom_range(0, 5);
                    send_vlq(ACC_W'(len), $urandom_range(0, 3));
                    repeat (len) send_byte(8'($urandom_range(0, 255)));
                    gen_running = 1'b0;
                end else if (kind < 85) begin
                    send_byte(8'($urandom_range(STATUS_SYS, STATUS_META - 1)));
                    len = $urandom_range(0, 5);
                    send_vlq(ACC_W'(len), $urandom_range(0, 3));
                    for (int i = 0; i < len; i++) begin
                        if (i == len - 1 && $urandom_range(0, 1) == 0) send_byte(SYSEX_END);
                        else send_byte(8'($urandom_range(0, 255)));
                    end
                    gen_running = 1'b0;
                end else begin
                    case ($urandom_range(0, 3))
                        0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                        1: begin
                            send_byte(STATUS_SYS);
                            repeat (5) send_byte(8'h80 | 8'($urandom_range(0, 127)));
                        end
                        2: begin
                            send_byte(STATUS_META);
                            send_byte(META_SEQSPEC);
                            send_vlq(ACC_W'($urandom), 0);
                            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                        end
                        default: begin
                            send_byte(STATUS_META);
                            send_byte(8'($urandom_range(8'h60, 8'h7E)));
                            send_byte(8'($urandom_range(0, 255)));
                        end
                    endcase
                    break;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        clear_parser();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_channel_events();
        test_meta_sysex();
        test_errors();
        test_backpressure();
        test_random_tracks(ITEM_TARGET);
        wait_drained();
        repeat (8) @(posedge aclk);
        $display("tb: %0d bytes sent, %0d results checked, %0d events completed",
                 bytes_sent, results_seen, events_seen);
        $display("tb: %0d sysex warnings, %0d results under a held error",
                 warnings_seen, errored_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
